### sv/iss_pkg.sv
// Shared types and constants for the integer stack with search.
`timescale 1ns / 1ps
package iss_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned CAP_W   = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_PEEK   = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_SEARCH = 3'd4
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
  } iss_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         position;
    logic [CNT_W-1:0]         count;
  } iss_out_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic push;      // take word from the cell above
    logic pop;       // take word from the cell below
    logic load_hit;  // compare own word against the key
    logic shift_hit; // move hit flags one cell towards the top
  } iss_cell_ctrl_t;

endpackage

### sv/iss_cell.sv
// One stack cell: a stored word and a search hit flag, linked to both neighbours.
`timescale 1ns / 1ps
module iss_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  iss_pkg::iss_cell_ctrl_t          ctrl_i,
  input  logic signed [iss_pkg::DATA_W-1:0] key_i,
  input  logic signed [iss_pkg::DATA_W-1:0] up_data_i,
  input  logic signed [iss_pkg::DATA_W-1:0] dn_data_i,
  input  logic                             dn_hit_i,
  output logic signed [iss_pkg::DATA_W-1:0] data_o,
  output logic                             hit_o
);
  import iss_pkg::*;

  logic signed [DATA_W-1:0] data_q, data_d;
  logic                     hit_q, hit_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.push) begin
      data_d = up_data_i;
    end else if (ctrl_i.pop) begin
      data_d = dn_data_i;
    end
  end

  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.load_hit) begin
      hit_d = (data_q == key_i);
    end else if (ctrl_i.shift_hit) begin
      hit_d = dn_hit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule

### sv/int_stack_with_search.sv
// Top level: bounded LIFO stack built as a chain of cells, with linear search.
//
//  channel  direction  handshake              payload
//  in       input      in_valid_i / in_stall_o   iss_in_t  (kind, value)
//  out      output     out_valid_o / out_stall_i iss_out_t (status, data, position, count)
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (capacity)
//
// The top of stack sits in cell 0 and the whole chain shifts by one cell per
// push or pop. Search on a non-empty stack first latches hit flags in every
// cell, then walks the flags up the chain to cell 0.
// Reset empties the stack and sets capacity to 256; cell words are left as is.
// Input is stalled during a search walk and while a result waits on a stalled
// output.
`timescale 1ns / 1ps
module int_stack_with_search #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  iss_pkg::iss_in_t             in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output iss_pkg::iss_out_t            out_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [iss_pkg::CAP_W-1:0]    cfg_data_i
);
  import iss_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned MW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CAP_W-1:0]  cap_q;
  logic [IW-1:0]     idx_q, idx_d;
  logic [IW-1:0]     last_q, last_d;
  logic              found_q, found_d;
  logic              out_valid_q, out_valid_d;
  iss_out_t          out_q, out_d;

  iss_cell_ctrl_t           ctrl;
  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic                     cell_hit  [DEPTH];

  logic          out_free, accept, out_load, is_full, hit_top, scan_end;
  logic          found_any;
  logic [IW-1:0] top_idx, hit_idx, pos_idx;
  logic [CW+CNT_W-1:0] count_ext;
  logic [IW+POS_W-1:0] pos_ext;

  // Cell chain: cell 0 is the top of stack
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] up_data, dn_data;
    logic                     dn_hit;
    if (g == 0) begin : g_first
      assign up_data = in_i.value;
    end else begin : g_mid_up
      assign up_data = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign dn_data = cell_data[g];
      assign dn_hit  = 1'b0;
    end else begin : g_mid_dn
      assign dn_data = cell_data[g+1];
      assign dn_hit  = cell_hit[g+1];
    end
    iss_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .key_i     (in_i.value),
      .up_data_i (up_data),
      .dn_data_i (dn_data),
      .dn_hit_i  (dn_hit),
      .data_o    (cell_data[g]),
      .hit_o     (cell_hit[g])
    );
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q == ST_SCAN) || !out_free;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign is_full = (MW'(count_q) >= MW'(cap_q)) || (count_q == CW'(DEPTH));

  assign hit_top   = cell_hit[0];
  assign top_idx   = IW'(count_q - CW'(1));
  assign scan_end  = (idx_q == top_idx);
  assign found_any = found_q || hit_top;
  assign hit_idx   = hit_top ? idx_q : last_q;
  // walk index k maps to position count-1-k from the bottom
  assign pos_idx   = top_idx - hit_idx;
  assign pos_ext   = {{POS_W{1'b0}}, pos_idx};
  assign count_ext = {{CNT_W{1'b0}}, count_d};

  always_comb begin
    ctrl        = '0;
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    last_d      = last_q;
    found_d     = found_q;
    out_load    = 1'b0;
    out_d.status   = STAT_OK;
    out_d.data     = '0;
    out_d.position = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          unique case (in_i.kind)
            KIND_PUSH: begin
              if (is_full) begin
                out_d.status = STAT_FULL;
              end else begin
                ctrl.push = 1'b1;
                count_d   = count_q + CW'(1);
              end
            end
            KIND_POP, KIND_PEEK: begin
              if (count_q == '0) begin
                out_d.status = STAT_EMPTY;
              end else begin
                out_d.data = cell_data[0];
                if (in_i.kind == KIND_POP) begin
                  ctrl.pop = 1'b1;
                  count_d  = count_q - CW'(1);
                end
              end
            end
            KIND_CLEAR: begin
              count_d = '0;
            end
            KIND_SEARCH: begin
              if (count_q == '0) begin
                out_d.status = STAT_NOT_FOUND;
              end else begin
                ctrl.load_hit = 1'b1;
                out_load      = 1'b0;
                idx_d         = '0;
                found_d       = 1'b0;
                state_d       = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!scan_end) begin
          ctrl.shift_hit = 1'b1;
          idx_d          = idx_q + IW'(1);
          if (hit_top) begin
            found_d = 1'b1;
            last_d  = idx_q;
          end
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (found_any) begin
            out_d.position = pos_ext[POS_W-1:0];
          end else begin
            out_d.status = STAT_NOT_FOUND;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_d.count = count_ext[CNT_W-1:0];
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cap_q       <= CAP_RESET;
      idx_q       <= '0;
      last_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      last_q      <= last_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (out_load) begin
        out_q <= out_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### tb/tb.sv
// Testbench for int_stack_with_search: directed table, then random phases checked by a predictor.
`timescale 1ns / 1ps
module tb;
  import iss_pkg::*;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_NEG1 = 32'shFFFF_FFFF;
  localparam logic [CAP_W-1:0] CAP_ALL_ONES = 9'h1FF;

  typedef struct {
    bit               set_cap;
    logic [CAP_W-1:0] cap;
    iss_in_t          req;
    bit               typed;
    iss_out_t         res;
  } plan_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  iss_in_t           in_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  iss_out_t          out_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CAP_W-1:0]  cfg_data_i = '0;

  // Shadow of the stack held by the block
  logic signed [DATA_W-1:0] words [STACK_DEPTH];
  int unsigned              held = 0;
  logic [CAP_W-1:0]         cap_reg = CAP_RESET;

  iss_out_t    results_due [$];
  plan_row_t   plan [$];
  int          n_bad = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          stall_burst = 0;
  int unsigned cycle_cnt = 0;

  int_stack_with_search #(
    .DEPTH(STACK_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Applies one request to the shadow stack and returns the result it should give
  function automatic iss_out_t stack_apply(iss_in_t req);
    iss_out_t    res;
    int unsigned lim;
    res = '0;
    lim = (cap_reg > STACK_DEPTH) ? STACK_DEPTH : cap_reg;
    case (req.kind)
      KIND_PUSH: begin
        if (held >= lim) begin
          res.status = STAT_FULL;
        end else begin
          words[held] = req.value;
          held++;
        end
      end
      KIND_POP, KIND_PEEK: begin
        if (held == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.data = words[held-1];
          if (req.kind == KIND_POP) held--;
        end
      end
      KIND_CLEAR: held = 0;
      KIND_SEARCH: begin
        res.status = STAT_NOT_FOUND;
        for (int i = 0; i < held; i++) begin
          if (res.status == STAT_NOT_FOUND && words[i] == req.value) begin
            res.status = STAT_OK;
            res.position = i[POS_W-1:0];
          end
        end
      end
      default: ;
    endcase
    res.count = held[CNT_W-1:0];
    return res;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_word();
    if ($urandom_range(1) == 0) return $urandom;
    return int'($urandom_range(15)) - 8;
  endfunction

  function automatic iss_in_t random_req(int push_pct, bit with_clear);
    iss_in_t req;
    int      r;
    req.value = pick_word();
    r = $urandom_range(99);
    if (r < push_pct) begin
      req.kind = KIND_PUSH;
    end else begin
      r = $urandom_range(99);
      if (r < 30) req.kind = KIND_POP;
      else if (r < 50) req.kind = KIND_PEEK;
      else if (r < 90) req.kind = KIND_SEARCH;
      else if (r < 95) req.kind = with_clear ? KIND_CLEAR : KIND_SEARCH;
      else req.kind = KIND_W'($urandom_range(7, 5));
    end
    // searches often look for a word that is really held
    if (req.kind == KIND_SEARCH && held != 0 && $urandom_range(2) == 0)
      req.value = words[$urandom_range(held - 1)];
    return req;
  endfunction

  function automatic plan_row_t row_pred(logic [KIND_W-1:0] kind, logic signed [DATA_W-1:0] value);
    plan_row_t row;
    row = '{default: '0};
    row.req = '{kind: kind, value: value};
    return row;
  endfunction

  function automatic plan_row_t row_typed(logic [KIND_W-1:0] kind,
                                          logic signed [DATA_W-1:0] value, status_e st,
                                          logic signed [DATA_W-1:0] data, int pos, int cnt);
    plan_row_t row;
    row = row_pred(kind, value);
    row.typed = 1'b1;
    row.res = '{status: st, data: data, position: pos[POS_W-1:0], count: cnt[CNT_W-1:0]};
    return row;
  endfunction

  function automatic plan_row_t row_cap(logic [CAP_W-1:0] cap);
    plan_row_t row;
    row = '{default: '0};
    row.set_cap = 1'b1;
    row.cap = cap;
    return row;
  endfunction

  // Offers one request, with random idle cycles first, and books its result once accepted
  task automatic issue(iss_in_t req, bit typed, iss_out_t typed_res);
    iss_out_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    res = stack_apply(req);
    results_due.push_back(typed ? typed_res : res);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    drain();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= cap;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cap_reg = cap;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(int n, int push_pct, bit with_clear);
    for (int i = 0; i < n; i++) issue(random_req(push_pct, with_clear), 1'b0, '0);
  endtask

  // Receiver: random stalls, or a long hold-off when a burst is requested
  always @(posedge clk_i) begin
    if (stall_burst != 0) begin
      out_stall_i <= 1'b1;
      stall_burst <= stall_burst - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    iss_out_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      want = '0;
      if (results_due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result: st=%0d data=%h pos=%0d cnt=%0d",
                                  out_o.status, out_o.data, out_o.position, out_o.count);
      end else begin
        want = results_due.pop_front();
        if (out_o.status !== want.status || out_o.data !== want.data ||
            out_o.position !== want.position || out_o.count !== want.count) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: exp st=%0d data=%h pos=%0d cnt=%0d, got st=%0d data=%h pos=%0d cnt=%0d",
                     want.status, want.data, want.position, want.count,
                     out_o.status, out_o.data, out_o.position, out_o.count);
        end
      end
    end
  end

  initial begin
    plan.push_back(row_typed(KIND_POP, 0, STAT_EMPTY, 0, 0, 0));
    plan.push_back(row_typed(KIND_PEEK, WORD_NEG1, STAT_EMPTY, 0, 0, 0));
    plan.push_back(row_typed(KIND_SEARCH, 0, STAT_NOT_FOUND, 0, 0, 0));
    plan.push_back(row_typed(KIND_PUSH, WORD_MAX, STAT_OK, 0, 0, 1));
    plan.push_back(row_typed(KIND_PUSH, WORD_MIN, STAT_OK, 0, 0, 2));
    plan.push_back(row_typed(KIND_PUSH, 0, STAT_OK, 0, 0, 3));
    plan.push_back(row_typed(KIND_PUSH, WORD_NEG1, STAT_OK, 0, 0, 4));
    plan.push_back(row_typed(KIND_PUSH, WORD_MAX, STAT_OK, 0, 0, 5));
    // duplicate word: lowest position wins
    plan.push_back(row_typed(KIND_SEARCH, WORD_MAX, STAT_OK, 0, 0, 5));
    plan.push_back(row_typed(KIND_SEARCH, WORD_NEG1, STAT_OK, 0, 3, 5));
    plan.push_back(row_pred(KIND_SEARCH, WORD_MIN));
    plan.push_back(row_typed(KIND_SEARCH, 32'sh5555_AAAA, STAT_NOT_FOUND, 0, 0, 5));
    plan.push_back(row_typed(KIND_PEEK, 0, STAT_OK, WORD_MAX, 0, 5));
    plan.push_back(row_typed(KIND_POP, 0, STAT_OK, WORD_MAX, 0, 4));
    plan.push_back(row_typed(KIND_SPARE_A, WORD_NEG1, STAT_OK, 0, 0, 4));
    plan.push_back(row_pred(KIND_SPARE_B, WORD_MIN));
    plan.push_back(row_pred(KIND_SPARE_C, 0));
    plan.push_back(row_pred(KIND_POP, 0));
    plan.push_back(row_typed(KIND_CLEAR, 123, STAT_OK, 0, 0, 0));
    plan.push_back(row_cap(0));
    plan.push_back(row_typed(KIND_PUSH, 1, STAT_FULL, 0, 0, 0));
    plan.push_back(row_cap(2));
    plan.push_back(row_pred(KIND_PUSH, 32'shAAAA_5555));
    plan.push_back(row_pred(KIND_PUSH, 32'sh1234_5678));
    plan.push_back(row_typed(KIND_PUSH, 7, STAT_FULL, 0, 0, 2));
    // limit lowered under the count: entries stay readable
    plan.push_back(row_cap(1));
    plan.push_back(row_typed(KIND_PUSH, 7, STAT_FULL, 0, 0, 2));
    plan.push_back(row_pred(KIND_SEARCH, 32'shAAAA_5555));
    plan.push_back(row_pred(KIND_POP, 0));
    plan.push_back(row_typed(KIND_PUSH, 9, STAT_FULL, 0, 0, 1));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].set_cap) set_capacity(plan[i].cap);
      else issue(plan[i].req, plan[i].typed, plan[i].res);
    end

    set_capacity(CAP_RESET);
    run_phase(60, 45, 1'b1);

    set_capacity(5);
    tx_idle_pct = 52;
    run_phase(50, 60, 1'b1);

    set_capacity(0);
    tx_idle_pct = 0;
    rx_stall_pct <= 52;
    run_phase(15, 50, 1'b1);

    // above the depth: the stack fills to the depth and then reports full
    set_capacity(CAP_ALL_ONES);
    tx_idle_pct = 22;
    rx_stall_pct <= 22;
    run_phase(300, 95, 1'b0);

    set_capacity(3);
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    stall_burst <= 200;
    run_phase(40, 20, 1'b0);

    set_capacity(CAP_W'($urandom_range(1, STACK_DEPTH)));
    tx_idle_pct = 22;
    rx_stall_pct <= 22;
    run_phase(40, 50, 1'b1);

    drain();
    repeat (2 * STACK_DEPTH) @(posedge clk_i);
    if (n_bad == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
